// ===== rtl/core/ijss_pkg.sv =====
// Shared types and constants of the isochronous joint speed scaler.
// No dependencies; imported by ijss_divider, the top level and the testbench.
package ijss_pkg;

    localparam int ANGLE_W    = 16;
    localparam int DELTA_W    = 16;
    localparam int SPEED_W    = 16;
    localparam int INDEX_W    = 4;
    localparam int PROD_W     = SPEED_W + DELTA_W;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // Register map (word index)
    localparam logic [REG_IDX_W-1:0] REG_REFERENCE_SPEED = '0;

    localparam logic [SPEED_W-1:0] REFERENCE_SPEED_RESET = 16'd2500;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/core/ijss_divider.sv =====
// Shared multiply-divide unit: one 16x16 product, then a restoring
// division by the maximum difference, one quotient bit per cycle. Uses ijss_pkg.
module ijss_divider
    import ijss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SPEED_W-1:0] mul_a,
    input  logic [DELTA_W-1:0] mul_b,
    input  logic [DELTA_W-1:0] divisor,
    output logic [SPEED_W-1:0] quotient,
    output div_status_t        status
);

    logic [DELTA_W-1:0] rem_reg;
    logic [DELTA_W-1:0] quo_reg;
    logic [DELTA_W-1:0] div_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [PROD_W-1:0]  product;
    logic [DELTA_W:0]   trial;
    logic [DELTA_W:0]   trial_diff;
    logic               fits;
    logic [DELTA_W-1:0] rem_next;

    assign product    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign trial      = {rem_reg, quo_reg[DELTA_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign fits       = (trial >= {1'b0, div_reg});
    assign rem_next   = fits ? trial_diff[DELTA_W-1:0] : trial[DELTA_W-1:0];

    // Upper product half is below a nonzero divisor >= mul_b, so 16 steps suffice.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= product[PROD_W-1:DELTA_W];
            quo_reg <= product[DELTA_W-1:0];
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DELTA_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/core/isochronous_joint_speed_scaler.sv =====
// Top level of the isochronous joint speed scaler: APB register, difference store,
// sequencer and result register. Depends on ijss_pkg and ijss_divider.
//
//  channel   direction  handshake          payload
//  s_*       in         s_valid / s_ready  s_target_angle, s_current_angle, s_last_joint
//  m_*       out        m_valid / m_ready  m_joint_index, m_joint_speed, m_last_speed
//  apb       in/out     psel / penable     paddr, pwdata, pwrite, prdata, pready
//
// A joint without the last flag is accepted and s_ready stays high.
// On a last joint, each stored joint goes through a memory read, a multiply-load,
// 16 division steps, the done strobe and the output transfer.
// s_ready is low from the last joint until the final speed transfer completes.
// A stalled m_ready holds the result register and the whole sequencer.
// aresetn is synchronous, active low; the difference store needs no clearing.
module isochronous_joint_speed_scaler
    import ijss_pkg::*;
#(
    parameter int MAX_JOINTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [ANGLE_W-1:0] s_target_angle,
    input  logic signed [ANGLE_W-1:0] s_current_angle,
    input  logic                  s_last_joint,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_W-1:0]    m_joint_index,
    output logic [SPEED_W-1:0]    m_joint_speed,
    output logic                  m_last_speed,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(MAX_JOINTS + 1);
    localparam int IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [SPEED_W-1:0] ref_speed_reg;
    logic [DELTA_W-1:0] max_delta_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   k_reg;

    logic [DELTA_W-1:0] store_mem [MAX_JOINTS];
    logic [DELTA_W-1:0] rd_data_reg;

    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_index_reg;
    logic [SPEED_W-1:0] m_speed_reg;
    logic               m_last_reg;

    logic               s_xfer;
    logic               m_xfer;
    logic               cfg_wr;
    logic               store_room;
    logic               k_is_last;
    logic [ANGLE_W:0]   diff;
    logic [ANGLE_W:0]   diff_abs;
    logic [DELTA_W-1:0] delta;
    logic               div_start;
    logic [SPEED_W-1:0] div_quotient;
    div_status_t        div_stat;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_REFERENCE_SPEED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_speed_reg <= REFERENCE_SPEED_RESET;
        end else if (cfg_wr) begin
            ref_speed_reg <= pwdata[SPEED_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_REFERENCE_SPEED) begin
            prdata = APB_DATA_W'(ref_speed_reg);
        end
    end

    // ---------------- input side ----------------
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_xfer     = s_valid && s_ready;
    assign store_room = (count_reg < CNT_W'(MAX_JOINTS));

    // Absolute difference needs 17 bits signed; its magnitude fits 16.
    assign diff     = {s_target_angle[ANGLE_W-1], s_target_angle}
                    - {s_current_angle[ANGLE_W-1], s_current_angle};
    assign diff_abs = diff[ANGLE_W] ? (~diff + 1'b1) : diff;
    assign delta    = diff_abs[DELTA_W-1:0];

    // Difference store: one write port on transfer, one registered read for the run.
    always_ff @(posedge aclk) begin
        if (s_xfer && store_room) begin
            store_mem[count_reg[IDX_W-1:0]] <= delta;
        end
        rd_data_reg <= store_mem[k_reg[IDX_W-1:0]];
    end

    // ---------------- sequencer ----------------
    assign m_xfer    = m_valid_reg && m_ready;
    assign k_is_last = ((k_reg + 1'b1) == count_reg);
    assign div_start = (state_reg == ST_LOAD);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_xfer && s_last_joint) state_next = ST_READ;
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (div_stat.done) state_next = ST_OUT;
            ST_OUT: begin
                if (m_xfer) begin
                    state_next = m_last_reg ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            max_delta_reg <= '0;
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    // Store the joint while room remains; drop it otherwise.
                    if (s_xfer && store_room) begin
                        count_reg <= count_reg + 1'b1;
                        if (delta > max_delta_reg) begin
                            max_delta_reg <= delta;
                        end
                    end
                    k_reg <= '0;
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (m_xfer) begin
                        m_valid_reg <= 1'b0;
                        k_reg       <= k_reg + 1'b1;
                        if (m_last_reg) begin
                            count_reg     <= '0;
                            max_delta_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result payload: a zero maximum forces every speed to zero.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV && div_stat.done) begin
            m_index_reg <= INDEX_W'(k_reg);
            m_speed_reg <= (max_delta_reg == '0) ? '0 : div_quotient;
            m_last_reg  <= k_is_last;
        end
    end

    ijss_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .mul_a    (ref_speed_reg),
        .mul_b    (rd_data_reg),
        .divisor  (max_delta_reg),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    assign m_valid       = m_valid_reg;
    assign m_joint_index = m_index_reg;
    assign m_joint_speed = m_speed_reg;
    assign m_last_speed  = m_last_reg;

    // ---------------- assertions ----------------
    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result is pending");

    a_speed_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_joint_speed <= ref_speed_reg))
        else $error("scaled speed exceeds reference speed");

    a_ready_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_speed) |=> (s_ready && count_reg == '0))
        else $error("block not ready and cleared after the final speed");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_JOINTS))
        else $error("joint count beyond store depth");

    a_div_idle_outside_run: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside the divide state");

endmodule

// ===== tb/sv/tb_isochronous_joint_speed_scaler.sv =====
// Self-checking testbench of isochronous_joint_speed_scaler: directed and random joint
// commands under varied idling and backpressure, checked against an in-bench predictor.
// Depends on ijss_pkg and the RTL of the block.
module tb_isochronous_joint_speed_scaler
    import ijss_pkg::*;
();

    localparam int MAX_JOINTS    = 16;
    localparam int CYCLE_LIMIT   = 2000000;
    // Idle cycles allowed after the last speed before the block counts as quiet.
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLDOFF_LEN   = 300;

    // Word index that decodes to no register.
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [INDEX_W-1:0] joint_index;
        logic [SPEED_W-1:0] joint_speed;
        logic               last_speed;
    } speed_result_t;

    // Clock, reset and all block inputs, known from time zero.
    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic signed [ANGLE_W-1:0] s_target_angle  = '0;
    logic signed [ANGLE_W-1:0] s_current_angle = '0;
    logic                      s_last_joint    = 1'b0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic [INDEX_W-1:0]        m_joint_index;
    logic [SPEED_W-1:0]        m_joint_speed;
    logic                      m_last_speed;
    logic                      psel            = 1'b0;
    logic                      penable         = 1'b0;
    logic                      pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr           = '0;
    logic [APB_DATA_W-1:0]     pwdata          = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    // Predictor state: shadow register, stored differences, running peak.
    logic [SPEED_W-1:0] ref_speed_shadow = REFERENCE_SPEED_RESET;
    logic [DELTA_W-1:0] delta_mem [MAX_JOINTS];
    logic [DELTA_W-1:0] peak_delta    = '0;
    int                 stored_joints = 0;
    speed_result_t      speed_queue [$];

    int fail_count     = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // Hold-off request: bump holdoff_seq to start a receiver stall set by holdoff_len.
    int holdoff_len  = 0;
    int holdoff_seq  = 0;
    int holdoff_seen = 0;
    int holdoff_left = 0;

    isochronous_joint_speed_scaler #(
        .MAX_JOINTS(MAX_JOINTS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_angle (s_target_angle),
        .s_current_angle(s_current_angle),
        .s_last_joint   (s_last_joint),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_joint_index  (m_joint_index),
        .m_joint_speed  (m_joint_speed),
        .m_last_speed   (m_last_speed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 aclk = ~aclk;

    // Watchdog: end the run if the traffic never drains.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: a requested hold-off wins over the random stall pattern.
    always @(posedge aclk) begin
        if (holdoff_seq != holdoff_seen) begin
            holdoff_seen <= holdoff_seq;
            holdoff_left <= holdoff_len;
            m_ready      <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checker: compare every speed transfer with the oldest expectation.
    always @(posedge aclk) begin
        speed_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (speed_queue.size() == 0) begin
                $display("%0t: unexpected speed transfer index %0d speed %0d last %0d",
                         $time, m_joint_index, m_joint_speed, m_last_speed);
                fail_count++;
            end else begin
                exp_r = speed_queue[0];
                speed_queue.delete(0);
                if (m_joint_index !== exp_r.joint_index) begin
                    $display("%0t: joint_index expected %0d actual %0d",
                             $time, exp_r.joint_index, m_joint_index);
                    fail_count++;
                end
                if (m_joint_speed !== exp_r.joint_speed) begin
                    $display("%0t: joint_speed expected %0d actual %0d",
                             $time, exp_r.joint_speed, m_joint_speed);
                    fail_count++;
                end
                if (m_last_speed !== exp_r.last_speed) begin
                    $display("%0t: last_speed expected %0d actual %0d",
                             $time, exp_r.last_speed, m_last_speed);
                    fail_count++;
                end
            end
        end
    end

    // Store the joint's absolute difference; on the last joint queue one speed per
    // stored joint, scaled against the peak, and start a fresh command.
    function automatic void predict_speeds(logic signed [ANGLE_W-1:0] target,
                                           logic signed [ANGLE_W-1:0] current,
                                           logic last);
        int            diff;
        logic [DELTA_W-1:0] delta;
        logic [PROD_W-1:0]  product;
        speed_result_t r;
        diff  = int'(target) - int'(current);
        delta = DELTA_W'(diff < 0 ? -diff : diff);
        // Drop joints beyond the store; they do not enter the peak either.
        if (stored_joints < MAX_JOINTS) begin
            delta_mem[stored_joints] = delta;
            if (delta > peak_delta)
                peak_delta = delta;
            stored_joints++;
        end
        if (!last)
            return;
        for (int k = 0; k < stored_joints; k++) begin
            product       = PROD_W'(ref_speed_shadow) * PROD_W'(delta_mem[k]);
            r.joint_index = INDEX_W'(k);
            // A zero peak means no joint moves: every speed is zero.
            r.joint_speed = (peak_delta == '0) ? '0 : SPEED_W'(product / PROD_W'(peak_delta));
            r.last_speed  = (k + 1 == stored_joints);
            speed_queue.push_back(r);
        end
        stored_joints = 0;
        peak_delta    = '0;
    endfunction

    // Offer one joint, after a random gap, and hold it until the transfer.
    // Leave s_valid high on return so a following joint can go back to back.
    task automatic send_joint(input logic signed [ANGLE_W-1:0] target,
                              input logic signed [ANGLE_W-1:0] current,
                              input logic last);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_target_angle  <= target;
        s_current_angle <= current;
        s_last_joint    <= last;
        do @(posedge aclk); while (!s_ready);
        predict_speeds(target, current, last);
        items_sent++;
    endtask

    // Pause the sender until every expected speed has arrived, then settle.
    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (speed_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (idx == REG_REFERENCE_SPEED)
            ref_speed_shadow = value[SPEED_W-1:0];
    endtask

    // Read back reference_speed and compare with the shadow copy.
    task automatic apb_check_speed_reg();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_REFERENCE_SPEED, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[SPEED_W-1:0] !== ref_speed_shadow) begin
            $display("%0t: reference_speed read expected %0d actual %0d",
                     $time, ref_speed_shadow, prdata[SPEED_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [ANGLE_W-1:0] extreme_angle();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // One well-formed command: mostly up to the store size, sometimes past it,
    // with full-range, small, zero or extreme differences.
    task automatic send_random_command();
        int len;
        int style;
        logic signed [ANGLE_W-1:0] t;
        logic signed [ANGLE_W-1:0] c;
        if ($urandom_range(0, 99) < 8)
            len = $urandom_range(MAX_JOINTS + 1, MAX_JOINTS + 4);
        else if ($urandom_range(0, 1) == 0)
            len = $urandom_range(1, 4);
        else
            len = $urandom_range(1, MAX_JOINTS);
        style = $urandom_range(0, 3);
        for (int j = 0; j < len; j++) begin
            case (style)
                0: begin
                    t = ANGLE_W'($urandom);
                    c = ANGLE_W'($urandom);
                end
                1: begin
                    c = ANGLE_W'($urandom);
                    t = c + ANGLE_W'($urandom_range(0, 64)) - ANGLE_W'(32);
                end
                2: begin
                    c = ANGLE_W'($urandom);
                    t = ($urandom_range(0, 9) == 0) ? c + 1'b1 : c;
                end
                default: begin
                    t = extreme_angle();
                    c = extreme_angle();
                end
            endcase
            send_joint(t, c, j == len - 1);
        end
    endtask

    // Reset value of the register and a single-joint command at that speed.
    task automatic test_reset_value();
        apb_check_speed_reg();
        send_joint(16'sd1000, -16'sd500, 1'b1);
    endtask

    // Angle extremes: largest positive and negative differences, zero, -32768, -1.
    task automatic test_field_extremes();
        send_joint(16'sh7FFF, 16'sh8000, 1'b0);
        send_joint(16'sh8000, 16'sh7FFF, 1'b0);
        send_joint(16'sh0000, 16'sh0000, 1'b0);
        send_joint(16'sh8000, 16'sh0000, 1'b0);
        send_joint(16'shFFFF, 16'sh0000, 1'b1);
    endtask

    // Zero maximum: no joint moves, so every speed is zero.
    task automatic test_zero_max();
        send_joint(16'sh8000, 16'sh8000, 1'b0);
        send_joint(16'sh7FFF, 16'sh7FFF, 1'b1);
    endtask

    // Too many joints: fill the store, then end the command on a dropped joint
    // whose large difference must not enter the peak.
    task automatic test_joint_overflow();
        for (int j = 0; j < MAX_JOINTS; j++)
            send_joint(ANGLE_W'(j * 37), ANGLE_W'(-j * 11), 1'b0);
        send_joint(16'sh7FFF, 16'sh8000, 1'b1);
    endtask

    // Register write and readback; a write to an unused index leaves it alone.
    task automatic test_register_access();
        wait_results_done();
        apb_write(REG_REFERENCE_SPEED, 32'h0000_FFFF);
        apb_check_speed_reg();
        apb_write(REG_SPARE, 32'h0000_1234);
        apb_check_speed_reg();
        send_joint(16'sd100, 16'sd0, 1'b0);
        send_joint(16'sd0, -16'sd200, 1'b1);
    endtask

    // Random commands under one idling pattern and one register setting.
    task automatic test_random_traffic(input idle_mode_t mode,
                                       input logic [APB_DATA_W-1:0] speed_word,
                                       input int n_items);
        int start;
        wait_results_done();
        apb_write(REG_REFERENCE_SPEED, speed_word);
        apb_check_speed_reg();
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = 62;
                recv_stall_pct  = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 62;
            end
            default: begin
                sender_idle_pct = 32;
                recv_stall_pct  = 32;
            end
        endcase
        start = items_sent;
        while (items_sent - start < n_items)
            send_random_command();
    endtask

    // Long receiver hold-off while the sender keeps offering commands, so the
    // block stalls with s_ready low; then drain, and send two more commands.
    task automatic test_backpressure();
        wait_results_done();
        apb_write(REG_REFERENCE_SPEED, {16'h0000, 16'($urandom)});
        apb_check_speed_reg();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        holdoff_len <= HOLDOFF_LEN;
        holdoff_seq <= holdoff_seq + 1;
        repeat (4) send_random_command();
        wait_results_done();
        recv_stall_pct = 20;
        repeat (2) send_random_command();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_reset_value();
        test_field_extremes();
        test_zero_max();
        test_joint_overflow();
        test_register_access();
        test_random_traffic(IDLE_NONE,     32'h0000_FFFF, 95);
        test_random_traffic(IDLE_SENDER,   32'h0000_0000, 95);
        test_random_traffic(IDLE_RECEIVER, 32'h0000_0001, 95);
        test_random_traffic(IDLE_BOTH,     $urandom,      95);
        test_backpressure();

        // Drain the last speeds, then let the block settle before the verdict.
        wait_results_done();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== isochronous_joint_speed_scaler.f =====
rtl/core/ijss_pkg.sv
rtl/core/ijss_divider.sv
rtl/core/isochronous_joint_speed_scaler.sv
tb/sv/tb_isochronous_joint_speed_scaler.sv
